// File: rtl/core/co2f_pkg.sv
// ----------------------------------------------------------------------------
// CO2 sensor frame engine package
// Shared types, command codes and the fixed command frame table.
// ----------------------------------------------------------------------------
package co2f_pkg;

   localparam int FRAME_BYTES = 9;
   localparam int IDX_W       = $clog2(FRAME_BYTES);
   localparam int TEMP_OFFSET = 44;

   localparam logic [7:0] FRAME_HEADER = 8'hFF;
   localparam logic [7:0] SENSOR_ADDR  = 8'h01;

   localparam logic OP_COMMAND    = 1'b0;
   localparam logic OP_REPLY_BYTE = 1'b1;

   localparam logic KIND_TX    = 1'b0;
   localparam logic KIND_REPLY = 1'b1;

   localparam logic [3:0] CMD_NONE        = 4'd0;
   localparam logic [3:0] CMD_READ_GAS    = 4'd1;
   localparam logic [3:0] CMD_RANGE_QUERY = 4'd2;
   localparam logic [3:0] CMD_ABC_ON      = 4'd7;
   localparam logic [3:0] CMD_ABC_OFF     = 4'd8;
   localparam logic [3:0] CMD_RANGE_2000  = 4'd9;
   localparam logic [3:0] CMD_RANGE_5000  = 4'd10;
   localparam logic [3:0] CMD_ZERO_CAL    = 4'd11;
   localparam logic [3:0] CMD_RESET       = 4'd12;
   localparam logic [3:0] CMD_READ_TEMP   = 4'd13;

   localparam logic [1:0] RANGE_NONE = 2'd0;
   localparam logic [1:0] RANGE_2000 = 2'd1;
   localparam logic [1:0] RANGE_5000 = 2'd2;

   typedef logic [FRAME_BYTES-1:0][7:0] frame_type;

   typedef struct packed {
      logic cmd_load;
      logic byte_load;
   } dec_ctl_type;

   typedef struct packed {
      logic              done;
      logic              frame_ok;
      logic [15:0]       reply_value;
      logic signed [8:0] temperature;
      logic              temperature_valid;
      logic [1:0]        range_set;
   } reply_result_type;

   function automatic logic has_frame(input logic [3:0] code);
      logic r;
      case (code)
         CMD_READ_GAS, CMD_RANGE_QUERY, CMD_ABC_ON, CMD_ABC_OFF, CMD_RANGE_2000,
         CMD_RANGE_5000, CMD_ZERO_CAL, CMD_RESET, CMD_READ_TEMP: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic frame_type frame_of(input logic [3:0] code);
      frame_type f;
      f    = '0;
      f[0] = FRAME_HEADER;
      f[1] = SENSOR_ADDR;
      case (code)
         CMD_READ_GAS, CMD_READ_TEMP: begin
            f[2] = 8'h86;
            f[8] = 8'h79;
         end
         CMD_RANGE_QUERY: begin
            f[2] = 8'h9B;
            f[8] = 8'h64;
         end
         CMD_ABC_ON: begin
            f[2] = 8'h79;
            f[3] = 8'hA0;
            f[8] = 8'hE6;
         end
         CMD_ABC_OFF: begin
            f[2] = 8'h79;
            f[8] = 8'h86;
         end
         CMD_RANGE_2000: begin
            f[2] = 8'h99;
            f[6] = 8'h07;
            f[7] = 8'hD0;
            f[8] = 8'h8F;
         end
         CMD_RANGE_5000: begin
            f[2] = 8'h99;
            f[6] = 8'h13;
            f[7] = 8'h88;
            f[8] = 8'hCB;
         end
         CMD_ZERO_CAL: begin
            f[2] = 8'h87;
            f[8] = 8'h78;
         end
         CMD_RESET: begin
            f[2] = 8'h78;
            f[8] = 8'h87;
         end
         default: begin
            f = '0;
         end
      endcase
      return f;
   endfunction

endpackage

// File: rtl/core/co2f_reply_decoder.sv
// ----------------------------------------------------------------------------
// CO2 sensor reply decoder
// Tracks the pending command, collects the nine reply bytes, checks header
// and checksum, and decodes the result on the final byte.
// ----------------------------------------------------------------------------
module co2f_reply_decoder
   import co2f_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  dec_ctl_type      ctl,
   input  logic [3:0]       command_code,
   input  logic [7:0]       rx_byte,
   output reply_result_type result
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

   logic [3:0]       pending_code_ff, pending_code_in;
   logic [IDX_W-1:0] reply_count_ff, reply_count_in;
   logic [7:0]       byte_sum_ff, byte_sum_in;
   logic             header_seen_ff, header_seen_in;
   logic [7:0]       gas_high_ff, gas_high_in;
   logic [7:0]       gas_low_ff, gas_low_in;
   logic [7:0]       temp_raw_ff, temp_raw_in;
   logic [7:0]       expect_sum;
   logic             ok;
   logic             active;

   always_comb begin
      pending_code_in = pending_code_ff;
      reply_count_in  = reply_count_ff;
      byte_sum_in     = byte_sum_ff;
      header_seen_in  = header_seen_ff;
      gas_high_in     = gas_high_ff;
      gas_low_in      = gas_low_ff;
      temp_raw_in     = temp_raw_ff;
      expect_sum      = 8'd0 - byte_sum_ff;
      ok              = header_seen_ff && (rx_byte == expect_sum);
      active          = ctl.byte_load && (pending_code_ff != CMD_NONE);
      result          = '0;

      if (ctl.cmd_load) begin
         pending_code_in = has_frame(command_code) ? command_code : CMD_NONE;
         reply_count_in  = '0;
         byte_sum_in     = '0;
         header_seen_in  = 1'b0;
      end else if (active) begin
         if (reply_count_ff == LAST_IDX) begin
            result.done     = 1'b1;
            result.frame_ok = ok;
            if (ok) begin
               result.reply_value = (pending_code_ff == CMD_READ_GAS) ?
                                    {gas_high_ff, gas_low_ff} : 16'd1;
               if (pending_code_ff == CMD_READ_GAS || pending_code_ff == CMD_READ_TEMP) begin
                  result.temperature       = $signed({1'b0, temp_raw_ff} - 9'(TEMP_OFFSET));
                  result.temperature_valid = 1'b1;
               end
               if (pending_code_ff == CMD_RANGE_2000) begin
                  result.range_set = RANGE_2000;
               end else if (pending_code_ff == CMD_RANGE_5000) begin
                  result.range_set = RANGE_5000;
               end
            end
            pending_code_in = CMD_NONE;
            reply_count_in  = '0;
            byte_sum_in     = '0;
            header_seen_in  = 1'b0;
         end else begin
            if (reply_count_ff == '0) begin
               header_seen_in = (rx_byte == FRAME_HEADER);
            end else begin
               byte_sum_in = byte_sum_ff + rx_byte;
               if (reply_count_ff == IDX_W'(2)) begin
                  gas_high_in = rx_byte;
               end else if (reply_count_ff == IDX_W'(3)) begin
                  gas_low_in = rx_byte;
               end else if (reply_count_ff == IDX_W'(4)) begin
                  temp_raw_in = rx_byte;
               end
            end
            reply_count_in = reply_count_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_code_ff <= CMD_NONE;
         reply_count_ff  <= '0;
         byte_sum_ff     <= '0;
         header_seen_ff  <= 1'b0;
      end else begin
         pending_code_ff <= pending_code_in;
         reply_count_ff  <= reply_count_in;
         byte_sum_ff     <= byte_sum_in;
         header_seen_ff  <= header_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      gas_high_ff <= gas_high_in;
      gas_low_ff  <= gas_low_in;
      temp_raw_ff <= temp_raw_in;
   end

endmodule

// File: rtl/core/co2_sensor_uart_frame_engine_unit.sv
// ----------------------------------------------------------------------------
// CO2 sensor UART frame engine
// Builds 9-byte command frames and decodes the 9-byte sensor replies.
// ----------------------------------------------------------------------------
// A command transaction that has a frame yields nine transmit-byte results,
// one per cycle while rsp_ready is high, and no request is taken until the
// ninth byte has moved into the result register; the frame byte counter
// selects each byte in turn. A frameless command yields a single result, and
// reply bytes stream at one per cycle while the result register is free;
// only the ninth byte of a reply yields a result. The result register lets a
// new request enter in the same cycle as the held result is taken.
module co2_sensor_uart_frame_engine_unit
   import co2f_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_op,
   input  logic [3:0]        req_command_code,
   input  logic [7:0]        req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_kind,
   output logic [7:0]        rsp_tx_byte,
   output logic              rsp_last,
   output logic              rsp_frame_ok,
   output logic [15:0]       rsp_reply_value,
   output logic signed [8:0] rsp_temperature,
   output logic              rsp_temperature_valid,
   output logic [1:0]        rsp_range_set
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

   logic              frame_active_ff, frame_active_in;
   logic [3:0]        frame_code_ff, frame_code_in;
   logic [IDX_W-1:0]  frame_idx_ff, frame_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff, rsp_kind_in;
   logic [7:0]        rsp_tx_byte_ff, rsp_tx_byte_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_frame_ok_ff, rsp_frame_ok_in;
   logic [15:0]       rsp_reply_value_ff, rsp_reply_value_in;
   logic signed [8:0] rsp_temperature_ff, rsp_temperature_in;
   logic              rsp_temp_valid_ff, rsp_temp_valid_in;
   logic [1:0]        rsp_range_set_ff, rsp_range_set_in;

   logic              out_free;
   logic              req_fire;
   frame_type         cur_frame;
   frame_type         new_frame;
   dec_ctl_type       dec_ctl;
   reply_result_type  dec_result;

   co2f_reply_decoder u_reply_decoder (
      .clock        (clock),
      .reset        (reset),
      .ctl          (dec_ctl),
      .command_code (req_command_code),
      .rx_byte      (req_rx_byte),
      .result       (dec_result)
   );

   always_comb begin
      out_free          = !rsp_valid_ff || rsp_ready;
      req_ready         = !frame_active_ff && out_free;
      req_fire          = req_valid && req_ready;
      dec_ctl.cmd_load  = req_fire && (req_op == OP_COMMAND);
      dec_ctl.byte_load = req_fire && (req_op == OP_REPLY_BYTE);
      cur_frame         = frame_of(frame_code_ff);
      new_frame         = frame_of(req_command_code);

      frame_active_in    = frame_active_ff;
      frame_code_in      = frame_code_ff;
      frame_idx_in       = frame_idx_ff;
      rsp_valid_in       = out_free ? 1'b0 : rsp_valid_ff;
      rsp_kind_in        = rsp_kind_ff;
      rsp_tx_byte_in     = rsp_tx_byte_ff;
      rsp_last_in        = rsp_last_ff;
      rsp_frame_ok_in    = rsp_frame_ok_ff;
      rsp_reply_value_in = rsp_reply_value_ff;
      rsp_temperature_in = rsp_temperature_ff;
      rsp_temp_valid_in  = rsp_temp_valid_ff;
      rsp_range_set_in   = rsp_range_set_ff;

      if (frame_active_ff && out_free) begin
         rsp_valid_in       = 1'b1;
         rsp_kind_in        = KIND_TX;
         rsp_tx_byte_in     = cur_frame[frame_idx_ff];
         rsp_last_in        = (frame_idx_ff == LAST_IDX);
         rsp_frame_ok_in    = 1'b0;
         rsp_reply_value_in = '0;
         rsp_temperature_in = '0;
         rsp_temp_valid_in  = 1'b0;
         rsp_range_set_in   = RANGE_NONE;
         if (frame_idx_ff == LAST_IDX) begin
            frame_active_in = 1'b0;
            frame_idx_in    = '0;
         end else begin
            frame_idx_in = frame_idx_ff + IDX_W'(1);
         end
      end else if (dec_ctl.cmd_load) begin
         rsp_valid_in       = 1'b1;
         rsp_last_in        = 1'b0;
         rsp_frame_ok_in    = 1'b0;
         rsp_reply_value_in = '0;
         rsp_temperature_in = '0;
         rsp_temp_valid_in  = 1'b0;
         rsp_range_set_in   = RANGE_NONE;
         if (has_frame(req_command_code)) begin
            rsp_kind_in     = KIND_TX;
            rsp_tx_byte_in  = new_frame[0];
            frame_active_in = 1'b1;
            frame_code_in   = req_command_code;
            frame_idx_in    = IDX_W'(1);
         end else begin
            rsp_kind_in    = KIND_REPLY;
            rsp_tx_byte_in = '0;
         end
      end else if (dec_ctl.byte_load && dec_result.done) begin
         rsp_valid_in       = 1'b1;
         rsp_kind_in        = KIND_REPLY;
         rsp_tx_byte_in     = '0;
         rsp_last_in        = 1'b0;
         rsp_frame_ok_in    = dec_result.frame_ok;
         rsp_reply_value_in = dec_result.reply_value;
         rsp_temperature_in = dec_result.temperature;
         rsp_temp_valid_in  = dec_result.temperature_valid;
         rsp_range_set_in   = dec_result.range_set;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_active_ff <= 1'b0;
         frame_idx_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         frame_active_ff <= frame_active_in;
         frame_idx_ff    <= frame_idx_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_code_ff      <= frame_code_in;
      rsp_kind_ff        <= rsp_kind_in;
      rsp_tx_byte_ff     <= rsp_tx_byte_in;
      rsp_last_ff        <= rsp_last_in;
      rsp_frame_ok_ff    <= rsp_frame_ok_in;
      rsp_reply_value_ff <= rsp_reply_value_in;
      rsp_temperature_ff <= rsp_temperature_in;
      rsp_temp_valid_ff  <= rsp_temp_valid_in;
      rsp_range_set_ff   <= rsp_range_set_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_kind              = rsp_kind_ff;
   assign rsp_tx_byte           = rsp_tx_byte_ff;
   assign rsp_last              = rsp_last_ff;
   assign rsp_frame_ok          = rsp_frame_ok_ff;
   assign rsp_reply_value       = rsp_reply_value_ff;
   assign rsp_temperature       = rsp_temperature_ff;
   assign rsp_temperature_valid = rsp_temp_valid_ff;
   assign rsp_range_set         = rsp_range_set_ff;

endmodule

// File: tb/co2_sensor_uart_frame_engine_unit_tb.sv
// ----------------------------------------------------------------------------
// CO2 sensor UART frame engine testbench
// Sends command codes and sensor reply bytes through the request channel and
// checks every transmit byte and decoded reply against a cycle-free model of
// the frame engine. The sender idles in bursts and the receiver stalls in
// changing patterns. A short directed part is followed by random sequences,
// most of them complete command and reply exchanges.
// ----------------------------------------------------------------------------
module co2_sensor_uart_frame_engine_unit_tb
   import co2f_pkg::*;
;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 90;
   localparam int TAIL_CYCLES  = 20;

   localparam logic [3:0] CMD_SPARE_5  = 4'd5;
   localparam logic [3:0] CMD_SPARE_15 = 4'd15;

   typedef struct packed {
      logic       op;
      logic [3:0] code;
      logic [7:0] rx_byte;
      logic       drain;
   } engine_req_type;

   typedef struct packed {
      logic              kind;
      logic [7:0]        tx_byte;
      logic              last;
      logic              frame_ok;
      logic [15:0]       reply_value;
      logic signed [8:0] temperature;
      logic              temperature_valid;
      logic [1:0]        range_set;
   } engine_rsp_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_op = 1'b0;
   logic [3:0]        req_command_code = 4'd0;
   logic [7:0]        req_rx_byte = 8'd0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_kind;
   logic [7:0]        rsp_tx_byte;
   logic              rsp_last;
   logic              rsp_frame_ok;
   logic [15:0]       rsp_reply_value;
   logic signed [8:0] rsp_temperature;
   logic              rsp_temperature_valid;
   logic [1:0]        rsp_range_set;

   engine_req_type pending_req[$];
   engine_rsp_type expected_rsp[$];

   logic [3:0] pend_code = CMD_NONE;
   int         rx_count = 0;
   logic [7:0] rx_sum = 8'd0;
   logic       hdr_ok = 1'b0;
   logic [7:0] gas_hi = 8'd0;
   logic [7:0] gas_lo = 8'd0;
   logic [7:0] temp_raw = 8'd0;

   logic req_took = 1'b0;
   int   cycle_count = 0;
   int   error_count = 0;
   int   commands_sent = 0;
   int   replies_decoded = 0;
   int   results_checked = 0;
   int   gap_left = 0;
   int   burst_left = 0;
   int   ready_mode = 0;
   int   ready_left = 0;
   int   ready_phase = 0;

   co2_sensor_uart_frame_engine_unit dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_op                (req_op),
      .req_command_code      (req_command_code),
      .req_rx_byte           (req_rx_byte),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_kind              (rsp_kind),
      .rsp_tx_byte           (rsp_tx_byte),
      .rsp_last              (rsp_last),
      .rsp_frame_ok          (rsp_frame_ok),
      .rsp_reply_value       (rsp_reply_value),
      .rsp_temperature       (rsp_temperature),
      .rsp_temperature_valid (rsp_temperature_valid),
      .rsp_range_set         (rsp_range_set)
   );

   always #1 clock = ~clock;

   // Command frame as nine bytes, header first; zero for codes with no frame.
   function automatic logic [71:0] cmd_frame(input logic [3:0] code);
      logic [47:0] body;
      logic [7:0]  sum;
      int          i;
      case (code)
         CMD_READ_GAS, CMD_READ_TEMP: body = 48'h86_00_00_00_00_00;
         CMD_RANGE_QUERY:             body = 48'h9B_00_00_00_00_00;
         CMD_ABC_ON:                  body = 48'h79_A0_00_00_00_00;
         CMD_ABC_OFF:                 body = 48'h79_00_00_00_00_00;
         CMD_RANGE_2000:              body = 48'h99_00_00_00_07_D0;
         CMD_RANGE_5000:              body = 48'h99_00_00_00_13_88;
         CMD_ZERO_CAL:                body = 48'h87_00_00_00_00_00;
         CMD_RESET:                   body = 48'h78_00_00_00_00_00;
         default:                     return '0;
      endcase
      sum = SENSOR_ADDR;
      for (i = 0; i < 6; i++) begin
         sum = sum + body[47-8*i -: 8];
      end
      return {FRAME_HEADER, SENSOR_ADDR, body, 8'h00 - sum};
   endfunction

   task automatic predict_frame_engine(input logic op, input logic [3:0] code,
                                       input logic [7:0] rx);
      engine_rsp_type r;
      logic [71:0]    f;
      logic           ok;
      int             i;
      if (op == OP_COMMAND) begin
         rx_count = 0;
         rx_sum   = 8'd0;
         hdr_ok   = 1'b0;
         f        = cmd_frame(code);
         if (f == '0) begin
            pend_code = CMD_NONE;
            r         = '0;
            r.kind    = KIND_REPLY;
            expected_rsp.push_back(r);
         end else begin
            pend_code = code;
            commands_sent++;
            for (i = 0; i < FRAME_BYTES; i++) begin
               r         = '0;
               r.kind    = KIND_TX;
               r.tx_byte = f[71-8*i -: 8];
               r.last    = (i == FRAME_BYTES - 1);
               expected_rsp.push_back(r);
            end
         end
      end else if (pend_code != CMD_NONE) begin
         if (rx_count == 0) begin
            hdr_ok = (rx == FRAME_HEADER);
         end else if (rx_count < FRAME_BYTES - 1) begin
            rx_sum = rx_sum + rx;
            if (rx_count == 2) gas_hi = rx;
            else if (rx_count == 3) gas_lo = rx;
            else if (rx_count == 4) temp_raw = rx;
         end
         if (rx_count < FRAME_BYTES - 1) begin
            rx_count++;
         end else begin
            ok         = hdr_ok && (rx == 8'h00 - rx_sum);
            r          = '0;
            r.kind     = KIND_REPLY;
            r.frame_ok = ok;
            if (ok) begin
               r.reply_value = (pend_code == CMD_READ_GAS) ? {gas_hi, gas_lo} : 16'd1;
               if (pend_code == CMD_READ_GAS || pend_code == CMD_READ_TEMP) begin
                  r.temperature       = {1'b0, temp_raw} - 9'(TEMP_OFFSET);
                  r.temperature_valid = 1'b1;
               end
               if (pend_code == CMD_RANGE_2000) r.range_set = RANGE_2000;
               else if (pend_code == CMD_RANGE_5000) r.range_set = RANGE_5000;
            end
            expected_rsp.push_back(r);
            replies_decoded++;
            pend_code = CMD_NONE;
            rx_count  = 0;
            rx_sum    = 8'd0;
            hdr_ok    = 1'b0;
         end
      end
   endtask

   task automatic report_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   task automatic check_response();
      engine_rsp_type want;
      engine_rsp_type got;
      got = {rsp_kind, rsp_tx_byte, rsp_last, rsp_frame_ok, rsp_reply_value,
             rsp_temperature, rsp_temperature_valid, rsp_range_set};
      if (expected_rsp.size() == 0) begin
         error_count++;
         $display("%0t: unexpected result, expected none, actual %h", $time, got);
      end else begin
         want = expected_rsp.pop_front();
         results_checked++;
         report_field("kind", 16'(want.kind), 16'(got.kind));
         report_field("tx_byte", 16'(want.tx_byte), 16'(got.tx_byte));
         report_field("last", 16'(want.last), 16'(got.last));
         report_field("frame_ok", 16'(want.frame_ok), 16'(got.frame_ok));
         report_field("reply_value", want.reply_value, got.reply_value);
         report_field("temperature", 16'(unsigned'(want.temperature)),
                      16'(unsigned'(got.temperature)));
         report_field("temperature_valid", 16'(want.temperature_valid),
                      16'(got.temperature_valid));
         report_field("range_set", 16'(want.range_set), 16'(got.range_set));
      end
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles.", cycle_count);
         $display("FAILED: results differ");
         $finish;
      end
      req_took = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) check_response();
         if (req_valid && req_ready) begin
            predict_frame_engine(req_op, req_command_code, req_rx_byte);
            req_took = 1'b1;
         end
      end
   end

   always @(negedge clock) begin
      engine_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_took) begin
         req_valid <= 1'b1;
      end else if (gap_left > 0) begin
         gap_left = gap_left - 1;
         req_valid <= 1'b0;
      end else if (pending_req.size() != 0 &&
                   !(pending_req[0].drain && expected_rsp.size() != 0)) begin
         nxt = pending_req.pop_front();
         req_op           <= nxt.op;
         req_command_code <= nxt.code;
         req_rx_byte      <= nxt.rx_byte;
         req_valid        <= 1'b1;
         if (burst_left > 0) begin
            burst_left = burst_left - 1;
         end else begin
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            burst_left = $urandom_range(0, 15);
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (ready_left == 0) begin
         ready_mode = $urandom_range(0, 3);
         ready_left = $urandom_range(8, 40);
      end else begin
         ready_left = ready_left - 1;
      end
      ready_phase = ready_phase + 1;
      case (ready_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= (ready_phase % 3 == 0);
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   task automatic push_item(input logic op, input logic [3:0] code, input logic [7:0] rx,
                            input logic drain);
      engine_req_type it;
      it.op      = op;
      it.code    = code;
      it.rx_byte = rx;
      it.drain   = drain;
      pending_req.push_back(it);
   endtask

   function automatic logic [7:0] pick_byte();
      int sel;
      sel = $urandom_range(0, 7);
      if (sel == 0) return 8'h00;
      if (sel == 1) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   // Sends the first n_bytes of a reply; the checksum is computed over body.
   task automatic push_reply(input logic [7:0] head, input logic [55:0] body,
                             input logic bad_sum, input int n_bytes);
      logic [7:0] frame_buf [9];
      logic [7:0] sum;
      int         i;
      sum          = 8'd0;
      frame_buf[0] = head;
      for (i = 0; i < 7; i++) begin
         frame_buf[i+1] = body[55-8*i -: 8];
         sum = sum + frame_buf[i+1];
      end
      frame_buf[8] = 8'h00 - sum;
      if (bad_sum) frame_buf[8] = frame_buf[8] ^ 8'($urandom_range(1, 255));
      for (i = 0; i < n_bytes; i++) begin
         push_item(OP_REPLY_BYTE, 4'($urandom_range(0, 15)), frame_buf[i], 1'b0);
      end
   endtask

   initial begin
      int          counted;
      int          seq_index;
      int          sel;
      int          n;
      int          i;
      logic [3:0]  code;
      logic [7:0]  head;
      logic [55:0] body;

      // A stray reply byte, codes without a frame, a full gas read at the extremes,
      // a reply cut short by a command, a stray byte after it and a 2000 range set.
      push_item(OP_REPLY_BYTE, CMD_NONE, 8'hFF, 1'b0);
      push_item(OP_COMMAND, CMD_NONE, 8'h00, 1'b0);
      push_item(OP_COMMAND, CMD_SPARE_15, 8'hFF, 1'b0);
      push_item(OP_COMMAND, CMD_READ_GAS, 8'h00, 1'b0);
      push_reply(FRAME_HEADER, 56'h86_FF_FF_FF_00_00_00, 1'b0, FRAME_BYTES);
      push_item(OP_COMMAND, CMD_READ_TEMP, 8'h5A, 1'b0);
      push_reply(FRAME_HEADER, 56'h86_00_00_00_00_00_00, 1'b0, 2);
      push_item(OP_COMMAND, CMD_SPARE_5, 8'h00, 1'b0);
      push_item(OP_REPLY_BYTE, CMD_NONE, 8'h00, 1'b0);
      push_item(OP_COMMAND, CMD_RANGE_2000, 8'h00, 1'b0);
      push_reply(FRAME_HEADER, 56'h99_00_00_00_00_07_D0, 1'b0, FRAME_BYTES);

      counted   = 0;
      seq_index = 0;
      while (counted < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 99);
         if (sel < 80) begin
            do code = 4'($urandom_range(0, 15)); while (cmd_frame(code) == '0);
            push_item(OP_COMMAND, code, pick_byte(), (seq_index % 7 == 0));
            for (i = 0; i < 7; i++) body[55-8*i -: 8] = pick_byte();
            head = FRAME_HEADER;
            n    = FRAME_BYTES;
            if (sel >= 55 && sel < 62) head = 8'($urandom_range(0, 254));
            if (sel >= 70) n = $urandom_range(0, FRAME_BYTES - 1);
            push_reply(head, body, (sel >= 62 && sel < 70), n);
            counted += 1 + n;
         end else if (sel < 90) begin
            do code = 4'($urandom_range(0, 15)); while (cmd_frame(code) != '0);
            push_item(OP_COMMAND, code, pick_byte(), 1'b0);
            counted++;
         end else begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++) push_item(OP_REPLY_BYTE, 4'($urandom_range(0, 15)),
                                              pick_byte(), 1'b0);
            counted += n;
         end
         seq_index++;
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_req.size() != 0 || req_valid) @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d framed commands and %0d decoded replies, %0d results compared.",
               commands_sent, replies_decoded, results_checked);
      if (error_count == 0 && expected_rsp.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches, %0d results still expected.", error_count,
                  expected_rsp.size());
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
